// File: sv/udmn_pkg.sv
package udmn_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 7;
  localparam int unsigned CntW  = 5;

  localparam logic [WordW-1:0] TwoPow31   = 32'h8000_0000;
  localparam logic [WordW-1:0] TwoPow31M1 = 32'h7FFF_FFFF;
  localparam logic [ExpW-1:0]  ExpStart   = 7'd31;
  localparam logic [ExpW-1:0]  ExpMax     = 7'd64;
  localparam logic [ExpW-1:0]  WordBits   = 7'd32;
  localparam logic [CntW-1:0]  CntLast    = 5'd31;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv1 = 4'b0010,
    StDiv2 = 4'b0100,
    StLoop = 4'b1000
  } state_e;

endpackage

// File: sv/unsigned_div_magic_number_core.sv
// Channel   Ports                               Handshake
// -------   ---------------------------------   -------------------------------
// input     divisor_i                           start_i & !busy_o
// result    magic_o, add_flag_o, shift_o        done_o, one cycle, no backpressure
//
// A single shared restoring divider (one bit per cycle) runs twice for 32 steps:
// first (2^32-d) mod d, then (2^31-1)/d. The exponent loop then runs 1 to 33
// steps, ending on the exit test or exponent 64, after which the result is
// registered. busy_o is high from accept until the result is registered; the
// receiver cannot stall. A zero divisor returns all-zero fields with done_o in
// the next cycle, and busy_o stays low.
// rst_ni clears the sequencer and the strobe asynchronously.
module unsigned_div_magic_number_core
  import udmn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [31:0]       divisor_i,
  output logic              done_o,
  output logic [31:0]       magic_o,
  output logic              add_flag_o,
  output logic signed [6:0] shift_o
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic             first_q, first_d;
  logic             done_q, done_d;

  logic [WordW-1:0] d_q, d_d;
  logic [WordW-1:0] q_q, q_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] nc_q, nc_d;
  logic [WordW-1:0] qa_q, qa_d;
  logic [WordW-1:0] ra_q, ra_d;
  logic             add_q, add_d;
  logic [WordW-1:0] magic_q, magic_d;
  logic             addf_q, addf_d;
  logic [ExpW-1:0]  shift_q, shift_d;

  // shared divider step
  logic [WordW:0]   div_sh;
  logic [WordW+1:0] div_diff;
  logic             div_ge;
  logic [WordW-1:0] div_rem;
  logic [WordW-1:0] div_quo;

  // exponent loop step
  logic [WordW:0]   ra2;
  logic             a_ge;
  logic [WordW:0]   rb2p;
  logic             b_ge;
  logic [WordW-1:0] gap;
  logic             cont;
  logic             add_hit;

  always_comb begin
    div_sh   = {rem_q, q_q[WordW-1]};
    div_diff = {1'b0, div_sh} - {2'b00, d_q};
    div_ge   = ~div_diff[WordW+1];
    div_rem  = div_ge ? div_diff[WordW-1:0] : div_sh[WordW-1:0];
    div_quo  = {q_q[WordW-2:0], div_ge};

    ra2  = {ra_q, 1'b0};
    a_ge = ra2 >= {1'b0, nc_q};
    rb2p = {rem_q, 1'b1};
    b_ge = rb2p >= {1'b0, d_q};
    add_hit = b_ge ? (q_q >= TwoPow31M1) : (q_q >= TwoPow31);
    gap  = d_q - 32'd1 - rem_q;
    cont = (exp_q < ExpMax) && ((qa_q < gap) || ((qa_q == gap) && (ra_q == '0)));
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    first_d = first_q;
    done_d  = 1'b0;
    d_d     = d_q;
    q_d     = q_q;
    rem_d   = rem_q;
    nc_d    = nc_q;
    qa_d    = qa_q;
    ra_d    = ra_q;
    add_d   = add_q;
    magic_d = magic_q;
    addf_d  = addf_q;
    shift_d = shift_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          d_d   = divisor_i;
          q_d   = 32'd0 - divisor_i;
          rem_d = '0;
          cnt_d = '0;
          add_d = 1'b0;
          if (divisor_i == '0) begin
            magic_d = '0;
            addf_d  = 1'b0;
            shift_d = '0;
            done_d  = 1'b1;
          end else begin
            state_d = StDiv1;
          end
        end
      end
      StDiv1: begin
        q_d   = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CntLast) begin
          nc_d    = ~div_rem;
          qa_d    = (~div_rem == TwoPow31) ? 32'd1 : 32'd0;
          ra_d    = (~div_rem == TwoPow31) ? 32'd0 : TwoPow31;
          q_d     = TwoPow31M1;
          rem_d   = '0;
          state_d = StDiv2;
        end
      end
      StDiv2: begin
        q_d   = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CntLast) begin
          exp_d   = ExpStart;
          first_d = 1'b1;
          state_d = StLoop;
        end
      end
      StLoop: begin
        if (first_q || cont) begin
          first_d = 1'b0;
          exp_d   = exp_q + 7'd1;
          qa_d    = {qa_q[WordW-2:0], a_ge};
          ra_d    = a_ge ? (ra2[WordW-1:0] - nc_q) : ra2[WordW-1:0];
          if (add_hit) begin
            add_d = 1'b1;
          end
          q_d   = {q_q[WordW-2:0], b_ge};
          rem_d = b_ge ? (rb2p[WordW-1:0] - d_q) : rb2p[WordW-1:0];
        end else begin
          magic_d = q_q + 32'd1;
          addf_d  = add_q;
          shift_d = exp_q - WordBits - {6'd0, add_q};
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    d_q     <= d_d;
    q_q     <= q_d;
    rem_q   <= rem_d;
    nc_q    <= nc_d;
    qa_q    <= qa_d;
    ra_q    <= ra_d;
    add_q   <= add_d;
    magic_q <= magic_d;
    addf_q  <= addf_d;
    shift_q <= shift_d;
  end

  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign magic_o    = magic_q;
  assign add_flag_o = addf_q;
  assign shift_o    = shift_q;

endmodule
